### hdl/dq_pkg.sv
package dq_pkg;

  localparam int DEPTH_DEFAULT = 1024;
  localparam int VALUE_W       = 32;
  localparam int COUNT_W       = 11;

  localparam logic signed [VALUE_W-1:0] NO_VALUE = '1;

  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_QUERY      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DONE = 1'b1
  } state_t;

  typedef struct packed {
    logic [2:0]                 kind;
    logic signed [VALUE_W-1:0]  value;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  popped_value;
    logic [1:0]                 status;
    logic [COUNT_W-1:0]         count;
    logic                       is_empty;
    logic signed [VALUE_W-1:0]  front_value;
    logic signed [VALUE_W-1:0]  back_value;
  } out_t;

endpackage

### hdl/dq_ram.sv
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/double_ended_queue_unit.sv
// Channel   Ports                     Transfer
// -------   -----------------------   ----------------------------------------
// input     start, busy, in_item      transaction when start && !busy
// result    out_valid, out_item       one-cycle strobe, always taken
//
// Per item, the accept cycle updates head/count and writes a push into the
// entry RAM or issues the RAM read of the new front/back for a pop; the next
// cycle drives the result strobe with busy high, so no new item is taken until
// that result is out. Front/back values are cached in registers; only a pop
// reads RAM. Synchronous active-low reset empties the queue; RAM contents are
// not cleared. Results cannot be stalled.
module double_ended_queue_unit #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  dq_pkg::in_t   in_item,
  output logic          out_valid,
  output dq_pkg::out_t  out_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  dq_pkg::state_t state_r, state_nxt;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic signed [dq_pkg::VALUE_W-1:0] front_r, front_nxt;
  logic signed [dq_pkg::VALUE_W-1:0] back_r, back_nxt;
  logic signed [dq_pkg::VALUE_W-1:0] popped_r, popped_nxt;
  dq_pkg::status_t status_r, status_nxt;
  logic fix_front_r, fix_front_nxt;
  logic fix_back_r, fix_back_nxt;

  logic accept;
  logic is_full, is_empty_now;
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [dq_pkg::VALUE_W-1:0] rdata;
  logic [SW-1:0] tail_sum, prev_sum;
  logic [AW-1:0] tail_idx, prev_idx, head_dec, head_inc;
  logic signed [dq_pkg::VALUE_W-1:0] front_cur, back_cur;

  assign accept       = start && !busy;
  assign is_full      = (cnt_r == DEPTH_C);
  assign is_empty_now = (cnt_r == '0);

  // ring positions: slot after the back, and the slot before the back
  assign tail_sum = SW'(head_r) + SW'(cnt_r);
  assign prev_sum = SW'(head_r) + SW'(cnt_r) - SW'(2);
  assign tail_idx = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
  assign prev_idx = (prev_sum >= DEPTH_S) ? AW'(prev_sum - DEPTH_S) : AW'(prev_sum);
  assign head_dec = (head_r == '0) ? LAST_IDX : head_r - AW'(1);
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);

  assign front_cur = fix_front_r ? $signed(rdata) : front_r;
  assign back_cur  = fix_back_r ? $signed(rdata) : back_r;

  always_comb begin
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    popped_nxt    = popped_r;
    status_nxt    = status_r;
    fix_front_nxt = fix_front_r;
    fix_back_nxt  = fix_back_r;
    we            = 1'b0;
    waddr         = tail_idx;
    raddr         = head_inc;
    if (state_r == dq_pkg::ST_DONE) begin
      front_nxt     = front_cur;
      back_nxt      = back_cur;
      fix_front_nxt = 1'b0;
      fix_back_nxt  = 1'b0;
    end
    if (accept) begin
      popped_nxt    = dq_pkg::NO_VALUE;
      status_nxt    = dq_pkg::STAT_OK;
      fix_front_nxt = 1'b0;
      fix_back_nxt  = 1'b0;
      case (in_item.kind)
        dq_pkg::KIND_PUSH_FRONT,
        dq_pkg::KIND_PUSH_BACK: begin
          if (is_full) begin
            status_nxt = dq_pkg::STAT_FULL;
          end else begin
            we      = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
            if (in_item.kind == dq_pkg::KIND_PUSH_FRONT) begin
              waddr     = head_dec;
              head_nxt  = head_dec;
              front_nxt = in_item.value;
              if (is_empty_now) begin
                back_nxt = in_item.value;
              end
            end else begin
              waddr    = tail_idx;
              back_nxt = in_item.value;
              if (is_empty_now) begin
                front_nxt = in_item.value;
              end
            end
          end
        end
        dq_pkg::KIND_POP_FRONT: begin
          if (is_empty_now) begin
            status_nxt = dq_pkg::STAT_EMPTY;
          end else begin
            popped_nxt    = front_r;
            head_nxt      = head_inc;
            cnt_nxt       = cnt_r - CW'(1);
            raddr         = head_inc;
            fix_front_nxt = (cnt_r > CW'(1));
          end
        end
        dq_pkg::KIND_POP_BACK: begin
          if (is_empty_now) begin
            status_nxt = dq_pkg::STAT_EMPTY;
          end else begin
            popped_nxt   = back_r;
            cnt_nxt      = cnt_r - CW'(1);
            raddr        = prev_idx;
            fix_back_nxt = (cnt_r > CW'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dq_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = dq_pkg::ST_DONE;
        end
      end
      dq_pkg::ST_DONE: state_nxt = dq_pkg::ST_IDLE;
      default:         state_nxt = dq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      dq_pkg::ST_IDLE: begin
      end
      dq_pkg::ST_DONE: begin
        busy      = 1'b1;
        out_valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_item.popped_value = popped_r;
    out_item.status       = status_r;
    out_item.count        = (dq_pkg::COUNT_W)'(cnt_r);
    out_item.is_empty     = (cnt_r == '0);
    out_item.front_value  = (cnt_r == '0) ? dq_pkg::NO_VALUE : front_cur;
    out_item.back_value   = (cnt_r == '0) ? dq_pkg::NO_VALUE : back_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dq_pkg::ST_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      fix_front_r <= 1'b0;
      fix_back_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      fix_front_r <= fix_front_nxt;
      fix_back_r  <= fix_back_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r  <= front_nxt;
    back_r   <= back_nxt;
    popped_r <= popped_nxt;
    status_r <= status_nxt;
  end

  dq_ram #(
    .WIDTH (dq_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_item.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count above depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted item gave no result");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == dq_pkg::STAT_FULL) |-> (cnt_r == DEPTH_C))
    else $error("full status with free entries");

endmodule

### bench/double_ended_queue_unit_tb.sv
module double_ended_queue_unit_tb;

  localparam int DEPTH = dq_pkg::DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int PHASE_ITEMS = 400;
  // codes above KIND_QUERY are unused and behave as a query
  localparam logic [2:0] KIND_LAST_CODE = 3'd7;

  typedef enum {FILLING, AT_LIMIT, DRAINING, MIXING} load_mode_t;

  // Mirror of the deque contents; predicts one result per transaction.
  class deque_mirror;
    logic signed [dq_pkg::VALUE_W-1:0] slots [DEPTH];
    int unsigned head;
    int unsigned held;
    dq_pkg::out_t expected_results [$];
    int errors;

    function new();
      head = 0;
      held = 0;
      errors = 0;
    endfunction

    function void note_transaction(dq_pkg::in_t item);
      dq_pkg::out_t r;
      r.popped_value = dq_pkg::NO_VALUE;
      r.status = dq_pkg::STAT_OK;
      case (item.kind)
        dq_pkg::KIND_PUSH_FRONT, dq_pkg::KIND_PUSH_BACK: begin
          if (held == DEPTH) begin
            r.status = dq_pkg::STAT_FULL;
          end else if (item.kind == dq_pkg::KIND_PUSH_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            slots[head] = item.value;
            held++;
          end else begin
            slots[(head + held) % DEPTH] = item.value;
            held++;
          end
        end
        dq_pkg::KIND_POP_FRONT, dq_pkg::KIND_POP_BACK: begin
          if (held == 0) begin
            r.status = dq_pkg::STAT_EMPTY;
          end else if (item.kind == dq_pkg::KIND_POP_FRONT) begin
            r.popped_value = slots[head];
            head = (head + 1) % DEPTH;
            held--;
          end else begin
            r.popped_value = slots[(head + held - 1) % DEPTH];
            held--;
          end
        end
        default: ;
      endcase
      r.count = held[dq_pkg::COUNT_W-1:0];
      r.is_empty = (held == 0);
      r.front_value = (held == 0) ? dq_pkg::NO_VALUE : slots[head];
      r.back_value = (held == 0) ? dq_pkg::NO_VALUE : slots[(head + held - 1) % DEPTH];
      expected_results = {expected_results, r};
    endfunction

    function void compare(string name, logic [31:0] exp, logic [31:0] got);
      if (got !== exp) begin
        $error("%s: expected %0h, actual %0h", name, exp, got);
        errors++;
      end
    endfunction

    function void check_result(dq_pkg::out_t got);
      dq_pkg::out_t exp;
      if (expected_results.size() == 0) begin
        $error("result strobe with no transaction pending");
        errors++;
        return;
      end
      exp = expected_results[0];
      expected_results.delete(0);
      compare("popped_value", exp.popped_value, got.popped_value);
      compare("status", 32'(exp.status), 32'(got.status));
      compare("count", 32'(exp.count), 32'(got.count));
      compare("is_empty", 32'(exp.is_empty), 32'(got.is_empty));
      compare("front_value", exp.front_value, got.front_value);
      compare("back_value", exp.back_value, got.back_value);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  dq_pkg::in_t in_item;
  logic out_valid;
  dq_pkg::out_t out_item;

  deque_mirror book = new();
  int cycles = 0;
  int idle_pct = 0;
  int quiet_left = 0;
  load_mode_t mode = FILLING;
  int mode_left = 0;

  double_ended_queue_unit #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // pre-edge values: a transaction is taken when start is high and busy low
  always @(posedge clk) begin
    if (rst_n && start && !busy) book.note_transaction(in_item);
    if (rst_n && out_valid) book.check_result(out_item);
  end

  function automatic logic signed [dq_pkg::VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return '0;
      3: return dq_pkg::NO_VALUE;
      default: return $urandom;
    endcase
  endfunction

  function automatic dq_pkg::in_t make_item(logic [2:0] kind);
    dq_pkg::in_t it;
    it.kind = kind;
    it.value = rand_value();
    return it;
  endfunction

  function automatic logic [2:0] pick_kind(int push_pct, int pop_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      return $urandom_range(0, 1) ? dq_pkg::KIND_PUSH_BACK : dq_pkg::KIND_PUSH_FRONT;
    end
    if (r < push_pct + pop_pct) begin
      return $urandom_range(0, 1) ? dq_pkg::KIND_POP_BACK : dq_pkg::KIND_POP_FRONT;
    end
    return 3'($urandom_range(dq_pkg::KIND_QUERY, KIND_LAST_CODE));
  endfunction

  // fill to the full store, linger there, drain to empty, churn, repeat
  function automatic logic [2:0] next_kind();
    case (mode)
      FILLING: begin
        if (book.held >= DEPTH) begin
          mode = AT_LIMIT;
          mode_left = 40;
        end
      end
      AT_LIMIT: begin
        if (mode_left == 0) mode = DRAINING;
      end
      DRAINING: begin
        if (book.held == 0) begin
          mode = MIXING;
          mode_left = 80;
        end
      end
      MIXING: begin
        if (mode_left == 0) mode = FILLING;
      end
      default: ;
    endcase
    if (mode_left > 0) mode_left--;
    case (mode)
      FILLING:  return pick_kind(94, 3);
      AT_LIMIT: return pick_kind(60, 35);
      DRAINING: return pick_kind(3, 94);
      default:  return pick_kind(40, 45);
    endcase
  endfunction

  task automatic send_item(input dq_pkg::in_t item);
    start <= 1'b1;
    in_item <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic maybe_pause();
    if (quiet_left > 0) begin
      quiet_left--;
    end else if ($urandom_range(0, 99) < 3) begin
      quiet_left = 20;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      in_item <= make_item(3'($urandom));
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, value extremes, head wrap, unused codes
    send_item(make_item(dq_pkg::KIND_QUERY));
    send_item(make_item(dq_pkg::KIND_POP_FRONT));
    send_item(make_item(dq_pkg::KIND_POP_BACK));
    send_item('{kind: dq_pkg::KIND_PUSH_BACK, value: 32'h7fffffff});
    send_item('{kind: dq_pkg::KIND_PUSH_FRONT, value: 32'h80000000});
    send_item('{kind: dq_pkg::KIND_PUSH_BACK, value: '0});
    send_item('{kind: dq_pkg::KIND_PUSH_FRONT, value: dq_pkg::NO_VALUE});
    for (int k = dq_pkg::KIND_QUERY; k <= KIND_LAST_CODE; k++) send_item(make_item(3'(k)));
    send_item(make_item(dq_pkg::KIND_POP_BACK));
    send_item(make_item(dq_pkg::KIND_POP_FRONT));
    send_item(make_item(dq_pkg::KIND_POP_FRONT));
    send_item(make_item(dq_pkg::KIND_POP_BACK));
    send_item(make_item(dq_pkg::KIND_POP_BACK));
    send_item(make_item(dq_pkg::KIND_PUSH_FRONT));
    send_item(make_item(dq_pkg::KIND_POP_BACK));
    send_item(make_item(dq_pkg::KIND_PUSH_BACK));
    send_item(make_item(dq_pkg::KIND_POP_FRONT));
    send_item(make_item(dq_pkg::KIND_POP_FRONT));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case (i / PHASE_ITEMS)
        1:       idle_pct = 76;
        3:       idle_pct = 11;
        default: idle_pct = 0;
      endcase
      send_item(make_item(next_kind()));
      maybe_pause();
    end
    start <= 1'b0;

    while (book.expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (book.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
